// ===== src/two_pivot_frame_transform_defines.svh =====
// Assertion macros shared by the two_pivot_frame_transform checkers.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef TWO_PIVOT_FRAME_TRANSFORM_DEFINES_SVH
`define TWO_PIVOT_FRAME_TRANSFORM_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define TPFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked at the same clock as the antecedent.
`define TPFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/tpft_pkg.sv =====
// Shared widths, codes and types for the two-pivot frame transform.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpft_pkg;

  localparam int CoordW         = 32;  // Q16.16 coordinates
  localparam int TrigW          = 18;  // Q1.16 cosine and sine
  localparam int TrigFrac       = 16;
  localparam int DiffW          = CoordW + 1;  // exact pivot difference
  localparam int VecW           = 60;  // vectoring x/y, headroom for CORDIC gain
  localparam int VecScale       = 24;
  localparam int RotW           = 33;  // rotation c/s in Q2.30
  localparam int RotFrac        = 30;
  localparam int CordicStepsDef = 16;
  localparam int CfgIdxW        = 3;

  localparam logic signed [RotW-1:0]  KinvQ30 = 33'sd652032874;
  localparam logic signed [TrigW-1:0] TrigOne = 18'sd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIVOT_A_X = 3'd0,
    CFG_PIVOT_A_Y = 3'd1,
    CFG_PIVOT_B_X = 3'd2,
    CFG_PIVOT_B_Y = 3'd3,
    CFG_MODE      = 3'd4
  } cfg_idx_e;

  // Quarter-turn taken out before vectoring
  typedef enum logic [1:0] {
    PRE_NONE = 2'd0,
    PRE_POS  = 2'd1,
    PRE_NEG  = 2'd2
  } pre_e;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [RotW-1:0] c;
    logic signed [RotW-1:0] s;
    pre_e                   pre;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic                    busy;
    logic signed [TrigW-1:0] cosine;
    logic signed [TrigW-1:0] sine;
  } trig_t;

endpackage

// ===== src/tpft_cordic_cell.sv =====
// One CORDIC cell: a vectoring micro-step and the matching rotation micro-step.
// Depends on tpft_pkg; chained by tpft_trig_unit.
`timescale 1ns / 1ps

module tpft_cordic_cell
  import tpft_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  cordic_t cell_i,
  output logic    vld_o,
  output cordic_t cell_o
);

  logic signed [VecW-1:0] xs, ys;
  logic signed [RotW-1:0] cs, ss;
  cordic_t cell_d, cell_q;
  logic    vld_q;

  always_comb begin
    xs     = $signed(cell_i.x) >>> STEP;
    ys     = $signed(cell_i.y) >>> STEP;
    cs     = $signed(cell_i.c) >>> STEP;
    ss     = $signed(cell_i.s) >>> STEP;
    cell_d = cell_i;
    // the same direction bit drives both rotations
    if (!cell_i.y[VecW-1]) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.c = cell_i.c - ss;
      cell_d.s = cell_i.s + cs;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.c = cell_i.c + ss;
      cell_d.s = cell_i.s - cs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

// ===== src/tpft_trig_unit.sv =====
// Frame cosine and sine: pivot difference, quarter-turn, CORDIC cell chain, rounding.
// Depends on tpft_pkg and tpft_cordic_cell.
`timescale 1ns / 1ps

module tpft_trig_unit
  import tpft_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] pivot_a_x_i,
  input  logic signed [CoordW-1:0] pivot_a_y_i,
  input  logic signed [CoordW-1:0] pivot_b_x_i,
  input  logic signed [CoordW-1:0] pivot_b_y_i,
  output trig_t                    trig_o
);

  localparam logic signed [RotW:0] RoundHalf = (RotW+1)'(1) <<< (RotFrac - TrigFrac - 1);
  localparam logic signed [RotW:0] TrigMax   = (RotW+1)'(65536);
  localparam logic signed [RotW:0] TrigMin   = -TrigMax;

  function automatic logic signed [TrigW-1:0] trig_round(input logic signed [RotW-1:0] v);
    logic signed [RotW:0] r;
    logic signed [RotW:0] q;
    r = {v[RotW-1], v} + RoundHalf;
    q = r >>> (RotFrac - TrigFrac);
    if (q > TrigMax) begin
      return TrigOne;
    end else if (q < TrigMin) begin
      return -TrigOne;
    end
    return q[TrigW-1:0];
  endfunction

  logic signed [DiffW-1:0] dx, dy, vx, vy;
  cordic_t                 prep_d, prep_q;
  logic                    prep_vld_q;
  logic [CORDIC_STEPS:0]   vld;
  cordic_t                 chain [CORDIC_STEPS+1];
  cordic_t                 fin;
  logic signed [RotW-1:0]  cu, su;
  logic signed [TrigW-1:0] cos_q, sin_q;

  // Difference and quarter-turn into the right half plane
  always_comb begin
    dx          = {pivot_b_x_i[CoordW-1], pivot_b_x_i} - {pivot_a_x_i[CoordW-1], pivot_a_x_i};
    dy          = {pivot_b_y_i[CoordW-1], pivot_b_y_i} - {pivot_a_y_i[CoordW-1], pivot_a_y_i};
    vx          = dx;
    vy          = dy;
    prep_d.pre  = PRE_NONE;
    if (dx[DiffW-1]) begin
      if (!dy[DiffW-1]) begin
        vx         = dy;
        vy         = -dx;
        prep_d.pre = PRE_POS;
      end else begin
        vx         = -dy;
        vy         = dx;
        prep_d.pre = PRE_NEG;
      end
    end
    prep_d.x    = {{(VecW-DiffW){vx[DiffW-1]}}, vx} <<< VecScale;
    prep_d.y    = {{(VecW-DiffW){vy[DiffW-1]}}, vy} <<< VecScale;
    prep_d.c    = KinvQ30;
    prep_d.s    = '0;
    prep_d.zero = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else begin
      prep_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign vld[0]   = prep_vld_q;
  assign chain[0] = prep_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    tpft_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[i]),
      .cell_i (chain[i]),
      .vld_o  (vld[i+1]),
      .cell_o (chain[i+1])
    );
  end

  assign fin = chain[CORDIC_STEPS];

  // Undo the quarter-turn
  always_comb begin
    unique case (fin.pre)
      PRE_POS: begin
        cu = -fin.s;
        su = fin.c;
      end
      PRE_NEG: begin
        cu = fin.s;
        su = -fin.c;
      end
      default: begin
        cu = fin.c;
        su = fin.s;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= TrigOne;
      sin_q <= '0;
    end else if (vld[CORDIC_STEPS]) begin
      if (fin.zero) begin
        cos_q <= TrigOne;
        sin_q <= '0;
      end else begin
        cos_q <= trig_round(cu);
        sin_q <= trig_round(su);
      end
    end
  end

  assign trig_o.busy   = start_i | (|vld);
  assign trig_o.cosine = cos_q;
  assign trig_o.sine   = sin_q;

endmodule

// ===== src/tpft_xform_pipe.sv =====
// Point pipeline: offset, four products, rounded sums, translate and clip.
// Depends on tpft_pkg; cosine and sine come from tpft_trig_unit.
`timescale 1ns / 1ps

module tpft_xform_pipe
  import tpft_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  trig_t                    trig_i,
  input  logic signed [CoordW-1:0] pivot_a_x_i,
  input  logic signed [CoordW-1:0] pivot_a_y_i,
  input  logic                     inverse_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic                     saturated_o
);

  localparam int ProdW = TrigW + DiffW;
  localparam int SumW  = ProdW + 1;
  localparam int RndW  = SumW - TrigFrac;
  localparam int FullW = RndW + 1;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) <<< (TrigFrac - 1);

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [DiffW-1:0] a_d, b_d, a_q, b_q;
  logic signed [ProdW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [SumW-1:0]  sx, sy;
  logic signed [RndW-1:0]  rx_q, ry_q;
  logic signed [FullW-1:0] fx, fy;
  logic                    clip_x, clip_y;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic                    sat_q;

  // Each stage moves when its successor is empty or moving
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  always_comb begin
    a_d = {point_x_i[CoordW-1], point_x_i};
    b_d = {point_y_i[CoordW-1], point_y_i};
    if (inverse_i) begin
      a_d = a_d - {pivot_a_x_i[CoordW-1], pivot_a_x_i};
      b_d = b_d - {pivot_a_y_i[CoordW-1], pivot_a_y_i};
    end
  end

  always_comb begin
    if (inverse_i) begin
      sx = {ca_q[ProdW-1], ca_q} + {sb_q[ProdW-1], sb_q};
      sy = {cb_q[ProdW-1], cb_q} - {sa_q[ProdW-1], sa_q};
    end else begin
      sx = {ca_q[ProdW-1], ca_q} - {sb_q[ProdW-1], sb_q};
      sy = {sa_q[ProdW-1], sa_q} + {cb_q[ProdW-1], cb_q};
    end
    sx = sx + RoundHalf;
    sy = sy + RoundHalf;
  end

  always_comb begin
    fx = {rx_q[RndW-1], rx_q};
    fy = {ry_q[RndW-1], ry_q};
    if (!inverse_i) begin
      fx = fx + {{(FullW-CoordW){pivot_a_x_i[CoordW-1]}}, pivot_a_x_i};
      fy = fy + {{(FullW-CoordW){pivot_a_y_i[CoordW-1]}}, pivot_a_y_i};
    end
    // in range only when all bits above the int32 sign agree with it
    clip_x = (fx[FullW-1:CoordW-1] != {(FullW-CoordW+1){fx[FullW-1]}});
    clip_y = (fy[FullW-1:CoordW-1] != {(FullW-CoordW+1){fy[FullW-1]}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
    if (rdy2 && v1_q) begin
      ca_q <= $signed(trig_i.cosine) * a_q;
      sb_q <= $signed(trig_i.sine) * b_q;
      sa_q <= $signed(trig_i.sine) * a_q;
      cb_q <= $signed(trig_i.cosine) * b_q;
    end
    if (rdy3 && v2_q) begin
      rx_q <= sx[SumW-1:TrigFrac];
      ry_q <= sy[SumW-1:TrigFrac];
    end
    if (rdy4 && v3_q) begin
      out_x_q <= clip_x ? (fx[FullW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}})
                        : fx[CoordW-1:0];
      out_y_q <= clip_y ? (fy[FullW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}})
                        : fy[CoordW-1:0];
      sat_q   <= clip_x | clip_y;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign saturated_o = sat_q;

endmodule

// ===== src/two_pivot_frame_transform.sv =====
// Top level of the two-pivot frame transform: configuration registers,
// trig unit and point pipeline. Depends on tpft_pkg, tpft_trig_unit, tpft_xform_pipe.
//
// Usage:
//   Write pivots A and B and the direction mode through cfg_we_i/cfg_idx_i/cfg_data_i.
//   Mode 0 maps local points to world (R*p + A), mode 1 maps world to local
//   (R^-1 * (p - A)); R turns the x axis onto the direction from A to B.
//   Points enter on s_axis (x in tdata[31:0], y in tdata[63:32], Q16.16) and
//   leave on m_axis in the same layout; m_axis_tuser flags a clipped result.
//   Throughput: one point per cycle while m_axis_tready is high and no pivot
//   update is running. An accepted request reaches m_axis_tvalid through the
//   four pipeline registers. A pivot write sends one token down the CORDIC cell
//   chain; s_axis_tready is low until the new cosine and sine are held.
//   Mode writes take effect at once.
//   When m_axis_tready is low the result holds and the pipeline keeps filling
//   empty stages; s_axis_tready drops once all four stages are full.
//   Reset clears the pipeline, sets pivot A to the origin, B to (1, 0), mode 0
//   and the rotation to identity; no sweep follows reset.
`timescale 1ns / 1ps

module two_pivot_frame_transform
  import tpft_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CoordW-1:0]     cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*CoordW-1:0]   s_axis_tdata,   // point_x, point_y
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*CoordW-1:0]   m_axis_tdata,   // out_x, out_y
  output logic [0:0]            m_axis_tuser    // saturated
);

  logic signed [CoordW-1:0] pivot_a_x_q, pivot_a_y_q, pivot_b_x_q, pivot_b_y_q;
  logic                     mode_q;
  logic                     start_q;
  trig_t                    trig;
  logic                     pipe_ready;
  logic signed [CoordW-1:0] out_x, out_y;
  logic                     saturated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_a_x_q <= '0;
      pivot_a_y_q <= '0;
      pivot_b_x_q <= CoordW'(65536);
      pivot_b_y_q <= '0;
      mode_q      <= 1'b0;
      start_q     <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PIVOT_A_X: begin
            pivot_a_x_q <= cfg_data_i;
            start_q     <= 1'b1;
          end
          CFG_PIVOT_A_Y: begin
            pivot_a_y_q <= cfg_data_i;
            start_q     <= 1'b1;
          end
          CFG_PIVOT_B_X: begin
            pivot_b_x_q <= cfg_data_i;
            start_q     <= 1'b1;
          end
          CFG_PIVOT_B_Y: begin
            pivot_b_y_q <= cfg_data_i;
            start_q     <= 1'b1;
          end
          CFG_MODE: mode_q <= cfg_data_i[0];
          default: ;  // drop writes to unused indexes
        endcase
      end
    end
  end

  tpft_trig_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_trig (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .pivot_a_x_i (pivot_a_x_q),
    .pivot_a_y_i (pivot_a_y_q),
    .pivot_b_x_i (pivot_b_x_q),
    .pivot_b_y_i (pivot_b_y_q),
    .trig_o      (trig)
  );

  // Hold requests while the frame is being recomputed
  assign s_axis_tready = pipe_ready && !trig.busy;

  tpft_xform_pipe u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && !trig.busy),
    .in_ready_o  (pipe_ready),
    .point_x_i   (s_axis_tdata[CoordW-1:0]),
    .point_y_i   (s_axis_tdata[2*CoordW-1:CoordW]),
    .trig_i      (trig),
    .pivot_a_x_i (pivot_a_x_q),
    .pivot_a_y_i (pivot_a_y_q),
    .inverse_i   (mode_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .saturated_o (saturated)
  );

  assign m_axis_tdata = {out_y, out_x};
  assign m_axis_tuser = saturated;

endmodule

// ===== src/tpft_checker.sv =====
// Port-level assertions for two_pivot_frame_transform, bound to the top level.
// Depends on tpft_pkg and two_pivot_frame_transform_defines.svh.
`timescale 1ns / 1ps
`include "two_pivot_frame_transform_defines.svh"

module tpft_checker
  import tpft_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_idx_i,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [2*CoordW-1:0] m_axis_tdata,
  input logic [0:0]          m_axis_tuser
);

  // a stalled result holds
  `TPFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // a pivot write blocks new requests while the frame is recomputed
  `TPFT_ASSERT_NEXT(a_pivot_blocks, clk_i, rst_ni, cfg_we_i && (cfg_idx_i == CFG_PIVOT_A_X || cfg_idx_i == CFG_PIVOT_A_Y || cfg_idx_i == CFG_PIVOT_B_X || cfg_idx_i == CFG_PIVOT_B_Y), !s_axis_tready, "request taken during frame update")

  // a clipped result sits on an int32 limit in at least one coordinate
  `TPFT_ASSERT_NOW(a_sat_limit, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] == 32'h7fffffff || m_axis_tdata[31:0] == 32'h80000000 || m_axis_tdata[63:32] == 32'h7fffffff || m_axis_tdata[63:32] == 32'h80000000, "saturated flag without a clipped value")

endmodule

bind two_pivot_frame_transform tpft_checker u_tpft_checker (.*);
